// ===== design/sdik_pkg.sv =====
`default_nettype none
package sdik_pkg;

	// Default number of CORDIC stages and the length of the arctangent table.
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES      = 24;

	// Fixed-point constants, angle in Q2.30 radians.
	localparam logic signed [34:0] PI_Q30       = 35'sd3373259426;
	localparam logic signed [34:0] TWO_PI_Q30   = 35'sd6746518852;
	localparam logic signed [34:0] HALF_PI_Q30  = 35'sd1686629713;
	localparam logic signed [62:0] INV_GAIN_Q30 = 63'sd652032874;

	// Saturation limits of the wheel speed, Q8.12.
	localparam logic signed [30:0] SPEED_MAX = 31'sd524287;
	localparam logic signed [30:0] SPEED_MIN = -31'sd524288;

	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_HALF_WHEELBASE  = 2'd0,
		REG_HALF_TRACKWIDTH = 2'd1,
		REG_SPEED_SCALE     = 2'd2
	} reg_index_t;

	// One wheel velocity vector handed from the front to the back, Q.12.
	typedef struct packed {
		logic [1:0]         idx;
		logic signed [20:0] tx;
		logic signed [20:0] ty;
	} wheel_vec_t;

	// Arctangent of 2^-i in Q2.30 radians.
	function automatic logic signed [34:0] atan_q30(input int unsigned i);
		logic signed [34:0] r;
		unique case (i)
			0:  r = 35'sd843314856;
			1:  r = 35'sd497837829;
			2:  r = 35'sd263043836;
			3:  r = 35'sd133525158;
			4:  r = 35'sd67021686;
			5:  r = 35'sd33543515;
			6:  r = 35'sd16775850;
			7:  r = 35'sd8388437;
			8:  r = 35'sd4194282;
			9:  r = 35'sd2097149;
			10: r = 35'sd1048575;
			11: r = 35'sd524287;
			12: r = 35'sd262143;
			13: r = 35'sd131071;
			14: r = 35'sd65535;
			15: r = 35'sd32767;
			16: r = 35'sd16383;
			17: r = 35'sd8191;
			18: r = 35'sd4095;
			19: r = 35'sd2047;
			20: r = 35'sd1023;
			21: r = 35'sd511;
			22: r = 35'sd255;
			23: r = 35'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/sdik_if.sv =====
`default_nettype none
// Command channel: one body velocity command per word.
interface sdik_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic signed [15:0] yaw_rate;
	modport source (output valid, vel_x, vel_y, yaw_rate, input ready);
	modport sink   (input valid, vel_x, vel_y, yaw_rate, output ready);
endinterface

// Result channel: one wheel per word.
interface sdik_wheel_if;
	logic               valid;
	logic               ready;
	logic [1:0]         wheel_index;
	logic signed [14:0] steer_angle;
	logic signed [19:0] wheel_speed;
	logic               last_wheel;
	modport source (output valid, wheel_index, steer_angle, wheel_speed, last_wheel,
		input ready);
	modport sink   (input valid, wheel_index, steer_angle, wheel_speed, last_wheel,
		output ready);
endinterface

// Configuration write channel.
interface sdik_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/sdik_front.sv =====
`default_nettype none
// Takes commands, forms the yaw terms and emits four wheel vectors.
module sdik_front (
	input  wire                      clk,
	input  wire                      arst_n,
	sdik_cmd_if.sink                 cmd,
	input  wire  [15:0]              half_wheelbase,
	input  wire  [15:0]              half_trackwidth,
	output logic                     vec_valid,
	output sdik_pkg::wheel_vec_t     vec,
	input  wire                      vec_ready
);
	logic               v_s1;
	logic signed [15:0] vx_s1, vy_s1, w_s1;
	logic               v_s2;
	logic signed [15:0] vx_s2, vy_s2;
	logic signed [20:0] wx_s2, wy_s2;
	logic [1:0]         k_q;
	logic               push, s2_free, s1_move;
	logic signed [32:0] px, py;
	logic signed [21:0] tx, ty;

	// The second stage frees up when it pushes its fourth wheel.
	assign push      = v_s2 && vec_ready;
	assign s2_free   = !v_s2 || (push && (k_q == 2'd3));
	assign s1_move   = v_s1 && s2_free;
	assign cmd.ready = !v_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			k_q  <= 2'd0;
		end else begin
			if (cmd.ready) v_s1 <= cmd.valid;
			if (s2_free) v_s2 <= s1_move;
			if (push) k_q <= k_q + 2'd1;
		end
	end

	// Command capture.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			vx_s1 <= cmd.vel_x;
			vy_s1 <= cmd.vel_y;
			w_s1  <= cmd.yaw_rate;
		end
	end

	// Yaw rate times the offsets, rounded half up to Q.12.
	assign px = 33'(w_s1) * $signed({17'd0, half_wheelbase});
	assign py = 33'(w_s1) * $signed({17'd0, half_trackwidth});

	always_ff @(posedge clk) begin
		if (s1_move) begin
			vx_s2 <= vx_s1;
			vy_s2 <= vy_s1;
			wx_s2 <= 21'((px + 33'sd2048) >>> 12);
			wy_s2 <= 21'((py + 33'sd2048) >>> 12);
		end
	end

	// Right wheels add the y term, rear wheels subtract the x term.
	always_comb begin
		tx = k_q[0] ? (22'(vx_s2) + 22'(wy_s2)) : (22'(vx_s2) - 22'(wy_s2));
		ty = k_q[1] ? (22'(vy_s2) - 22'(wx_s2)) : (22'(vy_s2) + 22'(wx_s2));
	end

	assign vec_valid = v_s2;
	assign vec.idx   = k_q;
	assign vec.tx    = tx[20:0];
	assign vec.ty    = ty[20:0];

endmodule
`default_nettype wire

// ===== design/sdik_queue.sv =====
`default_nettype none
// Short FIFO between the front and the back.
module sdik_queue (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  sdik_pkg::wheel_vec_t     in_vec,
	output logic                     out_valid,
	input  wire                      out_ready,
	output sdik_pkg::wheel_vec_t     out_vec
);
	localparam int AW = $clog2(sdik_pkg::QUEUE_DEPTH);

	sdik_pkg::wheel_vec_t mem_q [sdik_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign in_ready  = (cnt_q != (AW+1)'(sdik_pkg::QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign do_push   = in_valid && in_ready;
	assign do_pop    = out_valid && out_ready;
	assign out_vec   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= in_vec;
	end

endmodule
`default_nettype wire

// ===== design/sdik_back.sv =====
`default_nettype none
// CORDIC pipeline: angle and magnitude, folding, scaling, saturation.
module sdik_back #(
	parameter int CORDIC_STAGES = sdik_pkg::CORDIC_STAGES_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      vec_valid,
	output logic                     vec_ready,
	input  sdik_pkg::wheel_vec_t     vec,
	input  wire  [15:0]              speed_scale,
	sdik_wheel_if.source             wheel
);
	localparam int N = (CORDIC_STAGES < sdik_pkg::ATAN_ENTRIES) ?
		CORDIC_STAGES : sdik_pkg::ATAN_ENTRIES;

	logic en;

	logic               cv_s  [N+1];
	logic [1:0]         cidx_s[N+1];
	logic               czero_s[N+1];
	logic signed [31:0] cx_s  [N+1];
	logic signed [31:0] cy_s  [N+1];
	logic signed [34:0] cz_s  [N+1];

	logic               v_s3, zero_s3, neg_s3;
	logic [1:0]         idx_s3;
	logic signed [62:0] prod_s3;
	logic signed [14:0] ang_s3;

	logic               v_s4;
	logic [1:0]         idx_s4;
	logic signed [14:0] ang_s4;
	logic signed [38:0] sprod_s4;

	logic               v_s5;

	// The whole pipeline advances unless the output word is stalled.
	assign en        = !v_s5 || wheel.ready;
	assign vec_ready = en;

	// Pre-rotation by a quarter turn puts x on the right half plane.
	logic signed [31:0] x0, y0;
	always_comb begin
		x0 = 32'(vec.tx) <<< 8;
		y0 = 32'(vec.ty) <<< 8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else if (en) begin
			cv_s[0] <= vec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cidx_s[0]  <= vec.idx;
			czero_s[0] <= (vec.tx == '0) && (vec.ty == '0);
			if (x0 < 0) begin
				if (y0 >= 0) begin
					cx_s[0] <= y0;
					cy_s[0] <= -x0;
					cz_s[0] <= sdik_pkg::HALF_PI_Q30;
				end else begin
					cx_s[0] <= -y0;
					cy_s[0] <= x0;
					cz_s[0] <= -sdik_pkg::HALF_PI_Q30;
				end
			end else begin
				cx_s[0] <= x0;
				cy_s[0] <= y0;
				cz_s[0] <= '0;
			end
		end
	end

	// Vectoring stages, one microrotation each.
	for (genvar g = 0; g < N; g++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[g+1] <= 1'b0;
			end else if (en) begin
				cv_s[g+1] <= cv_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cidx_s[g+1]  <= cidx_s[g];
				czero_s[g+1] <= czero_s[g];
				if (cy_s[g] > 0) begin
					cx_s[g+1] <= cx_s[g] + (cy_s[g] >>> g);
					cy_s[g+1] <= cy_s[g] - (cx_s[g] >>> g);
					cz_s[g+1] <= cz_s[g] + sdik_pkg::atan_q30(g);
				end else begin
					cx_s[g+1] <= cx_s[g] - (cy_s[g] >>> g);
					cy_s[g+1] <= cy_s[g] + (cx_s[g] >>> g);
					cz_s[g+1] <= cz_s[g] - sdik_pkg::atan_q30(g);
				end
			end
		end
	end

	// Gain correction product; the angle is wrapped, folded and rounded.
	logic signed [34:0] zw, zf;
	logic               fold;
	logic signed [34:0] zr;
	always_comb begin
		if (cz_s[N] >= sdik_pkg::PI_Q30) begin
			zw = cz_s[N] - sdik_pkg::TWO_PI_Q30;
		end else if (cz_s[N] < -sdik_pkg::PI_Q30) begin
			zw = cz_s[N] + sdik_pkg::TWO_PI_Q30;
		end else begin
			zw = cz_s[N];
		end
		if (zw > sdik_pkg::HALF_PI_Q30) begin
			zf   = zw - sdik_pkg::PI_Q30;
			fold = 1'b1;
		end else if (zw < -sdik_pkg::HALF_PI_Q30) begin
			zf   = zw + sdik_pkg::PI_Q30;
			fold = 1'b1;
		end else begin
			zf   = zw;
			fold = 1'b0;
		end
		zr = (zf + 35'sd65536) >>> 17;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= cv_s[N];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s3  <= cidx_s[N];
			zero_s3 <= czero_s[N];
			neg_s3  <= fold;
			prod_s3 <= 63'(cx_s[N]) * sdik_pkg::INV_GAIN_Q30;
			ang_s3  <= zr[14:0];
		end
	end

	// Speed rounded to Q.12, sign applied, then scaled.
	logic signed [24:0] spd_full;
	logic signed [21:0] spd;
	always_comb begin
		spd_full = 25'((prod_s3 + (63'sd1 <<< 37)) >>> 38);
		if (zero_s3) begin
			spd = '0;
		end else if (neg_s3) begin
			spd = -spd_full[21:0];
		end else begin
			spd = spd_full[21:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s4   <= idx_s3;
			ang_s4   <= zero_s3 ? 15'sd0 : ang_s3;
			sprod_s4 <= 39'(spd) * $signed({23'd0, speed_scale});
		end
	end

	// Round from Q.20 to Q.12 and saturate.
	logic signed [30:0] ws;
	logic signed [19:0] ws_sat;
	always_comb begin
		ws = 31'((sprod_s4 + 39'sd128) >>> 8);
		if (ws > sdik_pkg::SPEED_MAX) begin
			ws_sat = sdik_pkg::SPEED_MAX[19:0];
		end else if (ws < sdik_pkg::SPEED_MIN) begin
			ws_sat = sdik_pkg::SPEED_MIN[19:0];
		end else begin
			ws_sat = ws[19:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wheel.wheel_index <= idx_s4;
			wheel.steer_angle <= ang_s4;
			wheel.wheel_speed <= ws_sat;
			wheel.last_wheel  <= (idx_s4 == 2'd3);
		end
	end

	assign wheel.valid = v_s5;

endmodule
`default_nettype wire

// ===== design/swerve_drive_inverse_kinematics.sv =====
`default_nettype none
// Channel   Direction  Words                                    Handshake
// cmd       in         vel_x, vel_y, yaw_rate                   valid/ready
// wheel     out        wheel_index, steer_angle, wheel_speed,   valid/ready
//                      last_wheel
// cfg       in         index, data                              valid/ready, always ready
//
// Each command gives four wheel words, one per cycle while the wheel channel is not
// stalled; the front's wheel emitter sets that rate. CORDIC_STAGES is capped at 24,
// the length of the arctangent table.
// Reset clears all valid state and loads the register defaults.
// A stalled wheel word freezes the back pipeline; the queue lets the front go on.
module swerve_drive_inverse_kinematics #(
	parameter int CORDIC_STAGES = sdik_pkg::CORDIC_STAGES_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	sdik_cmd_if.sink      cmd,
	sdik_wheel_if.source  wheel,
	sdik_cfg_if.sink      cfg
);
	logic [15:0] half_wheelbase_q, half_trackwidth_q, speed_scale_q;

	logic                 f_valid, f_ready, b_valid, b_ready;
	sdik_pkg::wheel_vec_t f_vec, b_vec;

	// Configuration registers; unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_wheelbase_q  <= 16'd1024;
			half_trackwidth_q <= 16'd1024;
			speed_scale_q     <= 16'd256;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sdik_pkg::REG_HALF_WHEELBASE:  half_wheelbase_q  <= cfg.data;
				sdik_pkg::REG_HALF_TRACKWIDTH: half_trackwidth_q <= cfg.data;
				sdik_pkg::REG_SPEED_SCALE:     speed_scale_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	sdik_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.half_wheelbase  (half_wheelbase_q),
		.half_trackwidth (half_trackwidth_q),
		.vec_valid       (f_valid),
		.vec             (f_vec),
		.vec_ready       (f_ready)
	);

	sdik_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_vec    (f_vec),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_vec   (b_vec)
	);

	sdik_back #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.vec_valid   (b_valid),
		.vec_ready   (b_ready),
		.vec         (b_vec),
		.speed_scale (speed_scale_q),
		.wheel       (wheel)
	);

endmodule
`default_nettype wire
